// ===== rtl/core/rcpn_pkg.sv =====
// Shared types, constants and a helper function for the Newton-Raphson reciprocal pipeline.
// No dependencies.
package rcpn_pkg;

    localparam int unsigned W              = 32;
    localparam int unsigned SHW            = 6;
    localparam int unsigned ITERATIONS_DEF = 10;

    typedef struct packed {
        logic valid;
        logic invalid;
    } t_ctl;

    function automatic logic [SHW-2:0] lead_one(input logic [W-1:0] v);
        logic [SHW-2:0] pos;
        pos = '0;
        for (int i = 0; i < W; i++) begin
            if (v[i]) begin
                pos = (SHW-1)'(i);
            end
        end
        return pos;
    endfunction

endpackage

// ===== rtl/core/rcpn_seed.sv =====
// Entry stage: flags divisors 0 and 1 and forms the 2^-k seed from the leading one.
// Depends on rcpn_pkg.
module rcpn_seed (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [rcpn_pkg::W-1:0] i_b,
    output rcpn_pkg::t_ctl        o_ctl,
    output logic [rcpn_pkg::W-1:0] o_b,
    output logic [rcpn_pkg::W-1:0] o_x
);
    import rcpn_pkg::*;

    logic [SHW-2:0] w_k;
    logic           w_inv;
    logic [W-1:0]   n_x;
    t_ctl           r_ctl;
    logic [W-1:0]   r_b;
    logic [W-1:0]   r_x;

    assign w_k   = lead_one(i_b);
    assign w_inv = (i_b[W-1:1] == '0);
    // zero seed stays zero through every step
    assign n_x   = w_inv ? '0 : (W'(1) << (SHW'(W) - {1'b0, w_k}));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl.valid   <= i_valid;
            r_ctl.invalid <= w_inv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b <= i_b;
            r_x <= n_x;
        end
    end

    assign o_ctl = r_ctl;
    assign o_b   = r_b;
    assign o_x   = r_x;

endmodule

// ===== rtl/core/rcpn_step.sv =====
// One Newton step x = x*(2 - B*x) in two register stages, one multiplier each.
// Depends on rcpn_pkg.
module rcpn_step (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  rcpn_pkg::t_ctl        i_ctl,
    input  logic [rcpn_pkg::W-1:0] i_b,
    input  logic [rcpn_pkg::W-1:0] i_x,
    output rcpn_pkg::t_ctl        o_ctl,
    output logic [rcpn_pkg::W-1:0] o_b,
    output logic [rcpn_pkg::W-1:0] o_x
);
    import rcpn_pkg::*;

    logic [2*W-1:0] w_bx;
    logic [W-1:0]   n_t;
    logic [2*W-1:0] w_xt;
    t_ctl           r_ctl_a;
    logic [W-1:0]   r_b_a;
    logic [W-1:0]   r_x_a;
    logic [W-1:0]   r_t_a;
    t_ctl           r_ctl_b;
    logic [W-1:0]   r_b_b;
    logic [W-1:0]   r_x_b;

    // p = (B*x mod 2^33) >> 1, t = -p
    assign w_bx = (2*W)'(i_b) * (2*W)'(i_x);
    assign n_t  = W'(0) - w_bx[W:1];
    // x' = (x * 2t mod 2^64) >> 32
    assign w_xt = (2*W)'(r_x_a) * (2*W)'(r_t_a);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl_a <= '0;
            r_ctl_b <= '0;
        end else if (i_en) begin
            r_ctl_a <= i_ctl;
            r_ctl_b <= r_ctl_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_a <= i_b;
            r_x_a <= i_x;
            r_t_a <= n_t;
            r_b_b <= r_b_a;
            r_x_b <= w_xt[2*W-2:W-1];
        end
    end

    assign o_ctl = r_ctl_b;
    assign o_b   = r_b_b;
    assign o_x   = r_x_b;

endmodule

// ===== rtl/core/fixed_point_reciprocal_newton.sv =====
// Top level of the Newton-Raphson reciprocal unit: seed stage, step chain, output skid.
// Depends on rcpn_pkg, rcpn_seed and rcpn_step.
// Returns 1/divisor as an unsigned Q0.32 fraction. The seed is 2^-k from the divisor's
// leading one, followed by ITERATIONS Newton steps with wrapping products. Divisors 0
// and 1 return zero with the flag in tuser set. One item is accepted per cycle while
// o_s_tready is high, that is while the output skid register is empty; there is one seed
// stage and two multiplier stages per step. The whole pipeline holds while its output
// skid register is occupied, so a stall costs nothing and loses nothing.
module fixed_point_reciprocal_newton #(
    parameter int unsigned ITERATIONS = rcpn_pkg::ITERATIONS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [rcpn_pkg::W-1:0] i_s_tdata,  // [31:0] divisor
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [rcpn_pkg::W-1:0] o_m_tdata,  // [31:0] reciprocal
    output logic                  o_m_tuser   // [0] invalid
);
    import rcpn_pkg::*;

    logic         w_en;
    t_ctl         w_ctl [0:ITERATIONS];
    logic [W-1:0] w_b   [0:ITERATIONS];
    logic [W-1:0] w_x   [0:ITERATIONS];
    logic         r_skid_valid;
    logic [W-1:0] r_skid_x;
    logic         r_skid_inv;

    assign w_en       = !r_skid_valid;
    assign o_s_tready = w_en;

    rcpn_seed u_seed (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_s_tvalid),
        .i_b     (i_s_tdata),
        .o_ctl   (w_ctl[0]),
        .o_b     (w_b[0]),
        .o_x     (w_x[0])
    );

    for (genvar g = 0; g < ITERATIONS; g++) begin : g_step
        rcpn_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_ctl   (w_ctl[g]),
            .i_b     (w_b[g]),
            .i_x     (w_x[g]),
            .o_ctl   (w_ctl[g+1]),
            .o_b     (w_b[g+1]),
            .o_x     (w_x[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (i_m_tready) begin
                r_skid_valid <= 1'b0;
            end
        end else if (w_ctl[ITERATIONS].valid && !i_m_tready) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_skid_valid) begin
            r_skid_x   <= w_x[ITERATIONS];
            r_skid_inv <= w_ctl[ITERATIONS].invalid;
        end
    end

    assign o_m_tvalid = r_skid_valid || w_ctl[ITERATIONS].valid;
    assign o_m_tdata  = r_skid_valid ? r_skid_x : w_x[ITERATIONS];
    assign o_m_tuser  = r_skid_valid ? r_skid_inv : w_ctl[ITERATIONS].invalid;

`ifndef SYNTHESIS
    a_inv_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tdata == '0)
        else $error("invalid item with nonzero reciprocal");

    a_skid_catch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_skid_valid && w_ctl[ITERATIONS].valid && !i_m_tready |=> r_skid_valid)
        else $error("stalled item not captured in skid");

    a_skid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid && !i_m_tready |=> r_skid_valid && $stable(r_skid_x)
            && $stable(r_skid_inv))
        else $error("skid item changed while stalled");

    a_pipe_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |=> $stable(w_ctl[ITERATIONS]) && $stable(w_x[ITERATIONS]))
        else $error("pipeline moved while skid occupied");
`endif

endmodule

// ===== verif/tb.sv =====
// Testbench for fixed_point_reciprocal_newton: directed and random divisors over four
// handshake-pressure phases, checked item by item against an in-bench Newton predictor.
// Depends on rcpn_pkg and the RTL of fixed_point_reciprocal_newton.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rcpn_pkg::*;

    localparam int unsigned STEPS   = ITERATIONS_DEF;
    localparam int unsigned LATENCY = 1 + 2 * STEPS;
    localparam int unsigned N_RAND  = 1450;

    typedef enum logic [1:0] {
        PH_STEADY,
        PH_SRC_IDLE,
        PH_SNK_STALL,
        PH_BOTH
    } t_phase;

    typedef struct {
        logic [W-1:0] recip;
        logic         invalid;
    } t_recip;

    logic         i_clk   = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_tvalid = 1'b0;
    logic         o_s_tready;
    logic [W-1:0] i_s_tdata = '0;   // [31:0] divisor
    logic         o_m_tvalid;
    logic         i_m_tready = 1'b0;
    logic [W-1:0] o_m_tdata;        // [31:0] reciprocal
    logic         o_m_tuser;        // [0] invalid

    t_phase       phase = PH_STEADY;
    int unsigned  src_idle_pct = 0;
    int unsigned  snk_stall_pct = 0;

    logic [W-1:0] divisor_q[$];
    t_recip       recip_expected_q[$];
    int unsigned  n_sent = 0;
    int unsigned  n_checked = 0;
    int unsigned  n_invalid = 0;
    int unsigned  n_errors = 0;

    fixed_point_reciprocal_newton #(
        .ITERATIONS(STEPS)
    ) u_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (i_s_tdata),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata (o_m_tdata),
        .o_m_tuser (o_m_tuser)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #400000;
        $display("TEST FAILED");
        $finish;
    end

    // seed 2^-k from the leading one, then Newton steps with the wrapping truncations
    function automatic t_recip newton_reciprocal(input logic [W-1:0] b);
        t_recip       r;
        int           msb;
        logic [W-1:0] x;
        logic [63:0]  prod;
        logic [W-1:0] p;
        logic [W-1:0] t;
        logic [63:0]  q;
        r.recip   = '0;
        r.invalid = 1'b1;
        if (b < 2) begin
            return r;
        end
        msb = 0;
        for (int i = 0; i < W; i++) begin
            if (b[i]) begin
                msb = i;
            end
        end
        x = W'(1) << (W - msb);
        for (int s = 0; s < STEPS; s++) begin
            prod = 64'(b) * 64'(x);
            p    = prod[32:1];
            t    = W'(0) - p;
            q    = 64'(x) * {31'd0, t, 1'b0};
            x    = q[63:32];
        end
        r.recip   = x;
        r.invalid = 1'b0;
        return r;
    endfunction

    function automatic logic [W-1:0] random_divisor();
        int unsigned  pick;
        int unsigned  msb;
        logic [W-1:0] v;
        pick = $urandom_range(99);
        msb  = $urandom_range(W - 1);
        v    = $urandom;
        if (pick < 50) begin
            return v;
        end else if (pick < 80) begin
            // random magnitude so that every leading-one position is reached
            return (v & ((W'(1) << msb) - 1)) | (W'(1) << msb);
        end else if (pick < 94) begin
            // near a power of two
            return (W'(1) << msb) + W'($urandom_range(2)) - W'($urandom_range(1));
        end else begin
            return W'($urandom_range(3));
        end
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            i_s_tdata  <= '0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                recip_expected_q.push_back(newton_reciprocal(i_s_tdata));
                n_sent <= n_sent + 1;
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (divisor_q.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= divisor_q.pop_front();
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_recip e;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= snk_stall_pct);
            if (o_m_tvalid === 1'b1 && i_m_tready) begin
                if (recip_expected_q.size() == 0) begin
                    $error("unexpected item: reciprocal %h invalid %b", o_m_tdata, o_m_tuser);
                    n_errors++;
                end else begin
                    e = recip_expected_q.pop_front();
                    if (o_m_tdata !== e.recip) begin
                        $error("reciprocal: expected %h, got %h", e.recip, o_m_tdata);
                        n_errors++;
                    end
                    if (o_m_tuser !== e.invalid) begin
                        $error("invalid: expected %b, got %b", e.invalid, o_m_tuser);
                        n_errors++;
                    end
                    n_checked++;
                    if (e.invalid) begin
                        n_invalid++;
                    end
                end
            end
        end
    end

    // sampled at the falling edge so the driver and monitor updates have settled
    task automatic drain();
        while (divisor_q.size() > 0 || i_s_tvalid || recip_expected_q.size() > 0) begin
            @(negedge i_clk);
        end
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic set_phase(input t_phase ph);
        @(negedge i_clk);
        phase = ph;
        case (ph)
            PH_STEADY: begin
                src_idle_pct  = 0;
                snk_stall_pct = 0;
            end
            PH_SRC_IDLE: begin
                src_idle_pct  = 63;
                snk_stall_pct = 0;
            end
            PH_SNK_STALL: begin
                src_idle_pct  = 0;
                snk_stall_pct = 63;
            end
            default: begin
                src_idle_pct  = 14;
                snk_stall_pct = 14;
            end
        endcase
    endtask

    initial begin
        logic [W-1:0] directed[$];
        directed = '{32'h0000_0000, 32'h0000_0001, 32'h0000_0002, 32'h0000_0003,
                     32'h0000_0005, 32'h0000_0007, 32'h0000_000A, 32'h0000_FFFF,
                     32'h0001_0000, 32'h0001_0001, 32'h5555_5555, 32'hAAAA_AAAA,
                     32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'hDEAD_BEEF,
                     32'hDEAF_BEEF, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'h4000_0000,
                     32'h0000_0100, 32'h0000_0000, 32'h0000_0001};
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        set_phase(PH_STEADY);
        foreach (directed[i]) begin
            divisor_q.push_back(directed[i]);
        end
        // sender holds off until every pending result is back
        drain();
        for (int ph = PH_STEADY; ph <= PH_BOTH; ph++) begin
            set_phase(t_phase'(ph));
            repeat (N_RAND / 4 + ((ph == PH_BOTH) ? N_RAND % 4 : 0)) begin
                divisor_q.push_back(random_divisor());
            end
            drain();
        end
        $display("Checked %0d reciprocals (%0d flagged invalid) from %0d divisors",
                 n_checked, n_invalid, n_sent);
        $display("across steady, source-idle, sink-stall and mixed handshake phases.");
        if (n_errors == 0 && recip_expected_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/rcpn_pkg.sv
rtl/core/rcpn_seed.sv
rtl/core/rcpn_step.sv
rtl/core/fixed_point_reciprocal_newton.sv
verif/tb.sv
